// ----- rtl/core/wps_pkg.sv -----
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants for the wheel-of-6 prime sieve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wps_pkg;

  localparam int unsigned DEF_MAP_BYTES = 4096;

  localparam int unsigned CFG_W            = 13;
  localparam logic [12:0] SIEVE_BYTES_RST  = 13'd4096;

  localparam int unsigned KIND_W      = 2;
  localparam int unsigned VALUE_W     = 18;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // map word: [7:0] bits of 6k+1, [15:8] bits of 6k+5, same k
  localparam int unsigned WORD_W = 16;

  // v / 6 as (v * RECIP_SIX) >> RECIP_SHIFT, exact for all 18-bit v
  localparam int unsigned QUOT_W      = 16;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [17:0] RECIP_SIX   = 18'd174763;

  typedef enum logic [1:0] {
    KIND_BUILD = 2'd0,
    KIND_TEST  = 2'd1,
    KIND_NTH   = 2'd2
  } kind_t;

endpackage

// ----- rtl/core/wheel6_prime_sieve.sv -----
// ----------------------------------------------------------------------------
// wheel6_prime_sieve
// Prime sieve on the wheel of 6. Two composite bitmaps (6k+1 and 6k+5) share
// one RAM word per byte index k/8. A build word clears the first built_bytes
// words, marks 1 composite and strikes out multiples of every unmarked base;
// a test word looks up one bit; an nth word scans the map and counts primes.
// One word is in work at a time; its result sits in an output register so the
// next word is taken while the result waits. A build strikes one multiple per
// cycle until the square of the base passes the map. The bitmap RAM has a
// single read port and a single write port and is used as a read-modify-write
// pipe with one-deep write forwarding. There is no clearing pass after reset:
// until the first build the map reads as all zeros.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel6_prime_sieve #(
  parameter int unsigned MAP_BYTES = wps_pkg::DEF_MAP_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [wps_pkg::CFG_W-1:0]       cfg_wr_data,  // sieve_bytes
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wps_pkg::IN_TDATA_W-1:0]  in_tdata,     // value[17:0], zero pad
  input  logic [wps_pkg::KIND_W-1:0]      in_tuser,     // kind[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wps_pkg::OUT_TDATA_W-1:0] out_tdata     // is_prime_flag[0],
                                                        // prime_value[18:1],
                                                        // out_of_range[19], zero pad
);
  import wps_pkg::*;

  localparam int unsigned AW  = $clog2(MAP_BYTES);      // RAM address
  localparam int unsigned BW  = $clog2(MAP_BYTES + 1);  // byte count
  localparam int unsigned LW  = BW + 3;                 // bit limit
  localparam int unsigned KW  = AW + 4;                 // bit index plus one step
  localparam int unsigned SQW = 2 * AW;
  localparam int unsigned SW  = 2 * AW + 4;             // 6*i*i + 6*i
  localparam int unsigned PW  = BW + 6;                 // 6k + 5
  localparam int unsigned CNW = VALUE_W + 1;
  localparam int unsigned PRIME_MAX = (1 << VALUE_W) - 1;
  localparam int unsigned BB_RST =
      (int'(SIEVE_BYTES_RST) > MAP_BYTES) ? MAP_BYTES : int'(SIEVE_BYTES_RST);
  localparam logic [WORD_W-1:0] ONE_LSB  = WORD_W'(1);
  localparam logic [WORD_W-1:0] FIVE_LSB = WORD_W'(1) << (WORD_W / 2);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_SQ, S_ST1, S_ST2, S_CK5, S_RD1, S_CK1, S_MARK,
    S_T0, S_T1, S_T2, S_N0, S_NRD, S_NBIT, S_OUT
  } state_t;

  // four strike runs per base index: b5 into five and one maps, b1 into one and five
  typedef enum logic [1:0] {RUN_A5, RUN_A1, RUN_B1, RUN_B5} run_t;

  function automatic logic [KW-1:0] clamp_start(input logic [SW-1:0] s,
                                                input logic [SW-1:0] lim);
    clamp_start = (s >= lim) ? KW'(lim) : KW'(s);
  endfunction

  state_t             state_r;
  run_t               run_r;
  logic [CFG_W-1:0]   sieve_bytes_r;
  logic [BW-1:0]      built_bytes_r;
  logic               built_r;
  logic [VALUE_W-1:0] item_value_r;

  logic [BW-1:0]  clr_r;
  logic [BW-1:0]  i_r;
  logic [SQW-1:0] sq_r;
  logic [SW-1:0]  six_i_r;
  logic [SW-1:0]  six_sq_r;
  logic [KW-1:0]  b5_r, b1_r;
  logic [KW-1:0]  sa_r, sb_r, sc_r, sd_r;
  logic [KW-1:0]  k_r;

  logic              p_valid_r;
  logic [AW-1:0]     p_addr_r;
  logic [WORD_W-1:0] p_mask_r;
  logic              w_valid_r;
  logic [AW-1:0]     w_addr_r;
  logic [WORD_W-1:0] w_data_r;
  logic [AW-1:0]     rd_addr_r;

  logic [BW-1:0]      word_r;
  logic [2:0]         sub_r;
  logic [VALUE_W-1:0] count_r;

  logic               res_flag_r, res_oor_r;
  logic [VALUE_W-1:0] res_prime_r;
  logic               out_valid_r, out_flag_r, out_oor_r;
  logic [VALUE_W-1:0] out_prime_r;

  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic [WORD_W-1:0] mem_rdata, mem_wdata;
  logic [WORD_W-1:0] fwd, map_word;

  logic [QUOT_W-1:0] div_quot;
  logic [2:0]        div_rem;

  logic [VALUE_W-1:0] in_value;
  kind_t              in_kind;
  logic [BW-1:0]      bb_new;
  logic [LW-1:0]      limit_w;
  logic [KW-1:0]      limit_k;
  logic [SW-1:0]      limit_s;
  logic [KW-1:0]      i_k, im1_k;
  logic [SW-1:0]      two_i, sa, sb, sc, sd;
  logic               mark_go, run_five, run_b;
  logic               n_one, n_five, found1, found2;
  logic [CNW-1:0]     c1, c2;
  logic [BW+2:0]      k_n;
  logic [PW-1:0]      six_k, cand;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_kind  = kind_t'(in_tuser);

  always_comb begin
    if (32'(sieve_bytes_r) < 32'd2) begin
      bb_new = BW'(2);
    end else if (32'(sieve_bytes_r) > 32'(MAP_BYTES)) begin
      bb_new = BW'(MAP_BYTES);
    end else begin
      bb_new = BW'(sieve_bytes_r);
    end
  end

  assign limit_w = {built_bytes_r, 3'b000};
  assign limit_k = KW'(limit_w);
  assign limit_s = SW'(limit_w);

  // one-deep forwarding covers a read on the same edge as the write
  assign fwd      = (w_valid_r && (w_addr_r == rd_addr_r)) ? w_data_r : mem_rdata;
  assign map_word = built_r ? fwd : '0;

  assign i_k   = KW'(i_r);
  assign im1_k = i_k - KW'(1);
  assign two_i = SW'(i_r) << 1;
  // b5*b1/6 = 6i^2-1, b5^2/6 = 6i^2-2i, b1^2/6 = 6i^2+2i, b1*(b5+6)/6 = 6i^2+6i
  assign sa = six_sq_r - SW'(1);
  assign sb = six_sq_r - two_i;
  assign sc = six_sq_r + two_i;
  assign sd = six_sq_r + six_i_r;

  assign mark_go  = (k_r < limit_k);
  assign run_five = (run_r == RUN_A5) || (run_r == RUN_B5);
  assign run_b    = (run_r == RUN_B1) || (run_r == RUN_B5);

  assign n_one  = map_word[{1'b0, sub_r}];
  assign n_five = map_word[{1'b1, sub_r}];
  assign c1     = {1'b0, count_r} + CNW'(!n_one);
  assign c2     = c1 + CNW'(!n_five);
  assign found1 = !n_one && (c1 == {1'b0, item_value_r});
  assign found2 = !n_five && (c2 == {1'b0, item_value_r});
  assign k_n    = {word_r, sub_r};
  assign six_k  = (PW'(k_n) << 2) + (PW'(k_n) << 1);
  assign cand   = six_k + (found1 ? PW'(1) : PW'(5));

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_r)
      S_ST2: begin
        mem_re    = 1'b1;
        mem_raddr = im1_k[AW+2:3];
      end
      S_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = i_k[AW+2:3];
      end
      S_MARK: begin
        mem_re    = mark_go;
        mem_raddr = k_r[AW+2:3];
      end
      S_T1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(div_quot >> 3);
      end
      S_NRD: begin
        mem_re    = 1'b1;
        mem_raddr = word_r[AW-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r[AW-1:0];
      mem_wdata = (clr_r == '0) ? ONE_LSB : '0;  // 1 is not prime
    end else begin
      mem_we    = p_valid_r;
      mem_waddr = p_addr_r;
      mem_wdata = fwd | p_mask_r;
    end
  end

  wps_map_ram #(
    .DEPTH (MAP_BYTES)
  ) u_map_ram (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  wps_div6 u_div6 (
    .clk   (clk),
    .en    (state_r == S_T0),
    .value (item_value_r),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      run_r         <= RUN_A5;
      sieve_bytes_r <= SIEVE_BYTES_RST;
      built_bytes_r <= BW'(BB_RST);
      built_r       <= 1'b0;
      item_value_r  <= '0;
      clr_r         <= '0;
      i_r           <= '0;
      sq_r          <= '0;
      six_i_r       <= '0;
      six_sq_r      <= '0;
      b5_r          <= '0;
      b1_r          <= '0;
      sa_r          <= '0;
      sb_r          <= '0;
      sc_r          <= '0;
      sd_r          <= '0;
      k_r           <= '0;
      p_valid_r     <= 1'b0;
      p_addr_r      <= '0;
      p_mask_r      <= '0;
      w_valid_r     <= 1'b0;
      w_addr_r      <= '0;
      w_data_r      <= '0;
      rd_addr_r     <= '0;
      word_r        <= '0;
      sub_r         <= '0;
      count_r       <= '0;
      res_flag_r    <= 1'b0;
      res_oor_r     <= 1'b0;
      res_prime_r   <= '0;
      out_valid_r   <= 1'b0;
      out_flag_r    <= 1'b0;
      out_oor_r     <= 1'b0;
      out_prime_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        sieve_bytes_r <= cfg_wr_data;
      end
      w_valid_r <= mem_we;
      w_addr_r  <= mem_waddr;
      w_data_r  <= mem_wdata;
      if (mem_re) begin
        rd_addr_r <= mem_raddr;
      end
      p_valid_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            item_value_r <= in_value;
            res_flag_r   <= 1'b0;
            res_oor_r    <= 1'b0;
            res_prime_r  <= '0;
            unique case (in_kind)
              KIND_BUILD: begin
                built_bytes_r <= bb_new;
                built_r       <= 1'b1;
                clr_r         <= '0;
                state_r       <= S_CLR;
              end
              KIND_TEST: state_r <= S_T0;
              KIND_NTH:  state_r <= S_N0;
              default:   state_r <= S_OUT;
            endcase
          end
        end

        S_CLR: begin
          if (clr_r == built_bytes_r - BW'(1)) begin
            i_r     <= BW'(1);
            state_r <= S_SQ;
          end else begin
            clr_r <= clr_r + BW'(1);
          end
        end

        S_SQ: begin
          if (i_r >= built_bytes_r) begin
            state_r <= S_OUT;
          end else begin
            sq_r    <= SQW'(i_r[AW-1:0]) * SQW'(i_r[AW-1:0]);
            six_i_r <= (SW'(i_r) << 2) + (SW'(i_r) << 1);
            state_r <= S_ST1;
          end
        end

        S_ST1: begin
          six_sq_r <= (SW'(sq_r) << 2) + (SW'(sq_r) << 1);
          b5_r     <= KW'(six_i_r - SW'(1));
          b1_r     <= KW'(six_i_r + SW'(1));
          state_r  <= S_ST2;
        end

        S_ST2: begin
          // smallest start past the map: no larger base strikes anything
          if (sb >= limit_s) begin
            state_r <= S_OUT;
          end else begin
            sa_r    <= clamp_start(sa, limit_s);
            sb_r    <= clamp_start(sb, limit_s);
            sc_r    <= clamp_start(sc, limit_s);
            sd_r    <= clamp_start(sd, limit_s);
            state_r <= S_CK5;
          end
        end

        S_CK5: begin
          if (!map_word[{1'b1, im1_k[2:0]}]) begin
            run_r   <= RUN_A5;
            k_r     <= sa_r;
            state_r <= S_MARK;
          end else begin
            state_r <= S_RD1;
          end
        end

        S_RD1: begin
          state_r <= S_CK1;
        end

        S_CK1: begin
          if (!map_word[{1'b0, i_k[2:0]}]) begin
            run_r   <= RUN_B1;
            k_r     <= sc_r;
            state_r <= S_MARK;
          end else begin
            i_r     <= i_r + BW'(1);
            state_r <= S_SQ;
          end
        end

        S_MARK: begin
          if (mark_go) begin
            p_valid_r <= 1'b1;
            p_addr_r  <= k_r[AW+2:3];
            p_mask_r  <= (run_five ? FIVE_LSB : ONE_LSB) << k_r[2:0];
            k_r       <= k_r + (run_b ? b1_r : b5_r);
          end else if (!p_valid_r) begin
            case (run_r)
              RUN_A5: begin
                run_r <= RUN_A1;
                k_r   <= sb_r;
              end
              RUN_A1: state_r <= S_RD1;
              RUN_B1: begin
                run_r <= RUN_B5;
                k_r   <= sd_r;
              end
              default: begin
                i_r     <= i_r + BW'(1);
                state_r <= S_SQ;
              end
            endcase
          end
        end

        S_T0: begin
          state_r <= S_T1;
        end

        S_T1: begin
          if (item_value_r == VALUE_W'(2) || item_value_r == VALUE_W'(3)) begin
            res_flag_r <= 1'b1;
            state_r    <= S_OUT;
          end else if (div_rem == 3'd1 || div_rem == 3'd5) begin
            if (32'(div_quot) >= 32'(limit_w)) begin
              res_oor_r <= 1'b1;
              state_r   <= S_OUT;
            end else begin
              state_r <= S_T2;
            end
          end else begin
            state_r <= S_OUT;
          end
        end

        S_T2: begin
          res_flag_r <= !map_word[{(div_rem == 3'd5), div_quot[2:0]}];
          state_r    <= S_OUT;
        end

        S_N0: begin
          if (item_value_r == '0) begin
            res_oor_r <= 1'b1;
            state_r   <= S_OUT;
          end else if (item_value_r == VALUE_W'(1)) begin
            res_prime_r <= VALUE_W'(2);
            state_r     <= S_OUT;
          end else if (item_value_r == VALUE_W'(2)) begin
            res_prime_r <= VALUE_W'(3);
            state_r     <= S_OUT;
          end else begin
            count_r <= VALUE_W'(2);
            word_r  <= '0;
            state_r <= S_NRD;
          end
        end

        S_NRD: begin
          if (word_r >= built_bytes_r) begin
            res_oor_r <= 1'b1;
            state_r   <= S_OUT;
          end else begin
            sub_r   <= '0;
            state_r <= S_NBIT;
          end
        end

        S_NBIT: begin
          if (found1 || found2) begin
            if (32'(cand) > 32'(PRIME_MAX)) begin
              res_oor_r <= 1'b1;
            end else begin
              res_prime_r <= VALUE_W'(cand);
            end
            state_r <= S_OUT;
          end else begin
            count_r <= VALUE_W'(c2);
            if (sub_r == 3'd7) begin
              word_r  <= word_r + BW'(1);
              state_r <= S_NRD;
            end else begin
              sub_r <= sub_r + 3'd1;
            end
          end
        end

        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_flag_r  <= res_flag_r;
            out_prime_r <= res_prime_r;
            out_oor_r   <= res_oor_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_oor_r, out_prime_r, out_flag_r});

  // strike pipe only fills from the strike state
  a_pipe_from_mark: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> ($past(state_r) == S_MARK))
    else $error("strike pipe loaded outside strike state");

  // clears and strikes stay inside the built part of the map
  a_write_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(mem_waddr) < 32'(built_bytes_r)))
    else $error("map write past built byte count");

  // the scan stops on the ordinal, never passes it
  a_count_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NBIT) |-> (count_r < item_value_r))
    else $error("prime count passed the ordinal");

endmodule

// ----- rtl/core/wps_map_ram.sv -----
// ----------------------------------------------------------------------------
// wps_map_ram
// Single-clock bitmap RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wps_map_ram #(
  parameter int unsigned DEPTH = wps_pkg::DEF_MAP_BYTES,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [wps_pkg::WORD_W-1:0] rdata,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [wps_pkg::WORD_W-1:0] wdata
);
  import wps_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // read returns the old word when the same entry is written on that edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/wps_div6.sv -----
// ----------------------------------------------------------------------------
// wps_div6
// Divide by six through a registered reciprocal multiply, with remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wps_div6 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [wps_pkg::VALUE_W-1:0] value,
  output logic [wps_pkg::QUOT_W-1:0]  quot,
  output logic [2:0]                  rem
);
  import wps_pkg::*;

  localparam int unsigned PW = VALUE_W + RECIP_W;

  logic [PW-1:0]      prod_r;
  logic [VALUE_W-1:0] val_r;
  logic [VALUE_W-1:0] six_q;
  logic [VALUE_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(value) * PW'(RECIP_SIX);
      val_r  <= value;
    end
  end

  assign quot  = prod_r[RECIP_SHIFT +: QUOT_W];
  assign six_q = (VALUE_W'(quot) << 2) + (VALUE_W'(quot) << 1);
  assign diff  = val_r - six_q;
  assign rem   = diff[2:0];

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the wheel-of-6 prime sieve word by word. A directed table covers
// lookups before and after the first build, the ends of the value and
// ordinal ranges and the unused kind. Random phases follow: each writes a new
// byte count, including the clamped extremes, and then sends mostly a build
// followed by primality tests and nth-prime queries. Both stream sides idle
// at random. Results are held to typed replies or an in-bench bitmap model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import wps_pkg::*;

  localparam int unsigned MAP_BYTES   = DEF_MAP_BYTES;
  localparam int unsigned WHEEL       = 6;
  localparam int unsigned VALUE_MAX   = 262143;
  localparam int unsigned NUM_PHASES  = 8;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic        flag;
    logic [17:0] prime;
    logic        oor;
  } sieve_reply_t;

  typedef struct packed {
    logic [1:0]   kind;
    logic [17:0]  value;
    logic         typed;
    sieve_reply_t reply;
  } probe_row_t;

  localparam sieve_reply_t NO_REPLY  = '{1'b0, 18'd0, 1'b0};
  localparam sieve_reply_t IS_PRIME  = '{1'b1, 18'd0, 1'b0};
  localparam sieve_reply_t PAST_SIEVE = '{1'b0, 18'd0, 1'b1};

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_W-1:0]       cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;    // value[17:0], zero pad
  logic [KIND_W-1:0]      in_tuser;    // kind[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;   // is_prime_flag[0], prime_value[18:1],
                                       // out_of_range[19], zero pad

  // model state: composite bits of 6k+1 and 6k+5, pending and latched byte counts
  logic [7:0]   comp_one  [MAP_BYTES];
  logic [7:0]   comp_five [MAP_BYTES];
  int unsigned  pend_sieve_bytes;
  int unsigned  live_bytes;

  sieve_reply_t pending_replies [$];
  int unsigned  mismatch_count = 0;
  bit           stall_on;
  bit           sender_idles;
  int unsigned  stall_left = 0;

  probe_row_t directed_rows [25] = '{
    '{KIND_TEST,   18'd0,      1'b1, NO_REPLY},
    '{KIND_TEST,   18'd1,      1'b1, IS_PRIME},      // unbuilt map: 1 reads prime
    '{KIND_TEST,   18'd2,      1'b1, IS_PRIME},
    '{KIND_TEST,   18'd3,      1'b1, IS_PRIME},
    '{KIND_TEST,   18'd4,      1'b1, NO_REPLY},
    '{KIND_TEST,   18'd262143, 1'b1, NO_REPLY},
    '{KIND_TEST,   18'd196607, 1'b1, IS_PRIME},      // last bit of the full map
    '{KIND_TEST,   18'd196609, 1'b1, PAST_SIEVE},
    '{KIND_TEST,   18'd25,     1'b1, IS_PRIME},
    '{KIND_NTH,    18'd0,      1'b1, PAST_SIEVE},
    '{KIND_NTH,    18'd1,      1'b1, '{1'b0, 18'd2, 1'b0}},
    '{KIND_NTH,    18'd2,      1'b1, '{1'b0, 18'd3, 1'b0}},
    '{KIND_NTH,    18'd3,      1'b0, NO_REPLY},
    '{KIND_UNUSED, 18'd262143, 1'b1, NO_REPLY},
    '{KIND_BUILD,  18'd0,      1'b1, NO_REPLY},      // reset byte count, full map
    '{KIND_TEST,   18'd25,     1'b1, NO_REPLY},
    '{KIND_TEST,   18'd1,      1'b1, NO_REPLY},
    '{KIND_TEST,   18'd5,      1'b1, IS_PRIME},
    '{KIND_TEST,   18'd196601, 1'b0, NO_REPLY},
    '{KIND_NTH,    18'd3,      1'b1, '{1'b0, 18'd5, 1'b0}},
    '{KIND_NTH,    18'd4,      1'b1, '{1'b0, 18'd7, 1'b0}},
    '{KIND_NTH,    18'd262143, 1'b1, PAST_SIEVE},    // scan runs off the map
    '{KIND_TEST,   18'd196609, 1'b1, PAST_SIEVE},
    '{KIND_NTH,    18'd17000,  1'b0, NO_REPLY},
    '{KIND_UNUSED, 18'd0,      1'b1, NO_REPLY}
  };

  wheel6_prime_sieve #(
    .MAP_BYTES(MAP_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic bit map_bit(input bit five, input int unsigned k);
    if ((k >> 3) >= MAP_BYTES) return 1'b0;
    return five ? comp_five[k >> 3][k % 8] : comp_one[k >> 3][k % 8];
  endfunction

  function automatic void strike(input bit five, input int unsigned start,
                                 input int unsigned step, input int unsigned lim);
    int unsigned k;
    for (k = start; k < lim; k += step) begin
      if ((k >> 3) < MAP_BYTES) begin
        if (five) comp_five[k >> 3][k % 8] = 1'b1;
        else comp_one[k >> 3][k % 8] = 1'b1;
      end
    end
  endfunction

  function automatic void rebuild_sieve();
    int unsigned i, b5, b1, lim;
    if (pend_sieve_bytes < 2) live_bytes = 2;
    else if (pend_sieve_bytes > MAP_BYTES) live_bytes = MAP_BYTES;
    else live_bytes = pend_sieve_bytes;
    for (i = 0; i < MAP_BYTES; i++) begin
      comp_one[i]  = 8'h00;
      comp_five[i] = 8'h00;
    end
    comp_one[0] = 8'h01;  // 1 is not prime
    lim = live_bytes * 8;
    for (i = 1; i < live_bytes; i++) begin
      b5 = WHEEL * i - 1;
      b1 = WHEEL * i + 1;
      if (!map_bit(1'b1, i - 1)) begin
        strike(1'b1, (b5 * b1) / WHEEL, b5, lim);
        strike(1'b0, (b5 * b5) / WHEEL, b5, lim);
      end
      if (!map_bit(1'b0, i)) begin
        strike(1'b0, (b1 * b1) / WHEEL, b1, lim);
        strike(1'b1, (b1 * (b5 + WHEEL)) / WHEEL, b1, lim);
      end
    end
  endfunction

  // expected reply for one accepted word; a build updates the maps
  function automatic sieve_reply_t answer_query(input logic [1:0] kind,
                                                input logic [17:0] value);
    sieve_reply_t rep;
    int unsigned  v, k, r, lim, count, pr;
    bit           found;
    rep = NO_REPLY;
    v   = value;
    lim = live_bytes * 8;
    case (kind)
      KIND_BUILD: begin
        rebuild_sieve();
      end
      KIND_TEST: begin
        k = v / WHEEL;
        r = v % WHEEL;
        if (v == 2 || v == 3) begin
          rep.flag = 1'b1;
        end else if (r == 1 || r == 5) begin
          if (k >= lim) rep.oor = 1'b1;
          else rep.flag = !map_bit(r == 5, k);
        end
      end
      KIND_NTH: begin
        if (v == 0) begin
          rep.oor = 1'b1;
        end else if (v == 1) begin
          rep.prime = 18'd2;
        end else if (v == 2) begin
          rep.prime = 18'd3;
        end else begin
          count = 2;
          found = 1'b0;
          pr    = 0;
          for (k = 0; k < lim && !found; k++) begin
            if (!map_bit(1'b0, k)) begin
              count++;
              if (count == v) begin
                pr    = WHEEL * k + 1;
                found = 1'b1;
              end
            end
            if (!found && !map_bit(1'b1, k)) begin
              count++;
              if (count == v) begin
                pr    = WHEEL * k + 5;
                found = 1'b1;
              end
            end
          end
          if (!found || pr > VALUE_MAX) rep.oor = 1'b1;
          else rep.prime = pr[17:0];
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // leaves in_tvalid high after the handshake; pace_sender lowers it when it idles
  task automatic send_query(input logic [1:0] kind, input logic [17:0] value,
                            input logic typed, input sieve_reply_t typed_reply);
    sieve_reply_t rep;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, value};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    rep = answer_query(kind, value);
    pending_replies.push_back(typed ? typed_reply : rep);
  endtask

  task automatic pace_sender();
    int unsigned gap, pick;
    gap  = 0;
    pick = $urandom_range(0, 9);
    if (sender_idles) begin
      if (pick >= 9) gap = $urandom_range(15, 60);
      else if (pick >= 5) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // result side: random stalls, mostly short, now and then long
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    sieve_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("word with no query pending", out_tdata, 0);
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata[0] !== want.flag)
          flag_mismatch("is_prime_flag", out_tdata[0], want.flag);
        if (out_tdata[18:1] !== want.prime)
          flag_mismatch("prime_value", out_tdata[18:1], want.prime);
        if (out_tdata[19] !== want.oor)
          flag_mismatch("out_of_range", out_tdata[19], want.oor);
      end
    end
  end

  initial begin : stimulus
    int unsigned idx, ph, j, n_items, pick, top, primes_seen, kk;
    logic [1:0]  kind;
    logic [17:0] value;
    logic [12:0] cfg_val;
    for (idx = 0; idx < MAP_BYTES; idx++) begin
      comp_one[idx]  = 8'h00;
      comp_five[idx] = 8'h00;
    end
    pend_sieve_bytes = SIEVE_BYTES_RST;
    live_bytes       = MAP_BYTES;
    sender_idles     = 1'b1;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    stall_on    <= 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < 25; idx++) begin
      send_query(directed_rows[idx].kind, directed_rows[idx].value,
                 directed_rows[idx].typed, directed_rows[idx].reply);
      pace_sender();
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       cfg_val = 13'd0;     // clamps up to 2
        1:       cfg_val = 13'd8191;  // clamps down to the full map
        2:       cfg_val = 13'd2;
        3:       cfg_val = 13'd3;
        7:       cfg_val = 13'($urandom_range(41, 600));
        default: cfg_val = 13'($urandom_range(4, 40));
      endcase
      wait_for_replies();
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cfg_val;
      @(posedge clk);
      pend_sieve_bytes = cfg_val;
      cfg_wr_en    <= 1'b0;
      stall_on     <= (ph % 3 != 2);
      sender_idles  = (ph % 3 != 2);
      n_items = (ph == 1) ? 6 : 13;

      for (j = 0; j < n_items; j++) begin
        if ($urandom_range(0, 19) == 0) wait_for_replies();
        pick = $urandom_range(0, 99);
        if (j == 0 && pick < 80) kind = KIND_BUILD;
        else if (pick < 6) kind = KIND_BUILD;
        else if (pick < 11) kind = KIND_UNUSED;
        else if (pick < 55) kind = KIND_TEST;
        else kind = KIND_NTH;

        value = 18'($urandom_range(0, VALUE_MAX));
        top   = 48 * live_bytes + 5;
        pick  = $urandom_range(0, 9);
        if (kind == KIND_TEST) begin
          if (pick < 7) value = 18'($urandom_range(0, top));
          else if (pick < 9) value = 18'($urandom_range(top - 20, top + 8));
        end else if (kind == KIND_NTH) begin
          primes_seen = 2;
          for (kk = 0; kk < live_bytes * 8; kk++)
            primes_seen += int'(!map_bit(1'b0, kk)) + int'(!map_bit(1'b1, kk));
          if (pick < 8) value = 18'($urandom_range(1, primes_seen + 1));
          else if (pick < 9) value = 18'($urandom_range(0, 3));
        end
        send_query(kind, value, 1'b0, NO_REPLY);
        pace_sender();
      end
    end

    wait_for_replies();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // slowest legal run ends well before the watchdog fires
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/wps_pkg.sv
rtl/core/wps_map_ram.sv
rtl/core/wps_div6.sv
rtl/core/wheel6_prime_sieve.sv
bench/testbench.sv
